/* rtl/srfe_pkg.sv */
// ----------------------------------------------------------------------------
// Serial reply field extractor package
// Shared character codes and the result records that the capture units
// hand to the top level.
// ----------------------------------------------------------------------------
package srfe_pkg;

  // Character codes seen on the serial link.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Widths of the reported index and length fields.
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned LEN_W  = 6;

  // Per-byte result of one capture unit.
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] index;
    logic             done;
    logic [LEN_W-1:0] length;
    logic             ovf;
  } cap_res_t;

endpackage

/* rtl/srfe_cmd_capture.sv */
// ----------------------------------------------------------------------------
// Command capture
// Starts on a dollar sign, stores bytes up to a carriage return, flags
// overflow past the depth and reports each write position and the final length.
// ----------------------------------------------------------------------------
module srfe_cmd_capture #(
  parameter int unsigned CMD_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output srfe_pkg::cap_res_t res
);

  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  logic             active_r;
  logic             active_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             active_eff;
  logic             is_cr;

  // A dollar sign opens the capture, also in the byte that carries it.
  assign active_eff = active_r || (rx_byte == srfe_pkg::CH_DOLLAR);
  assign is_cr      = (rx_byte == srfe_pkg::CH_CR);

  // Result and next state for the byte at hand.
  always_comb begin
    res        = '0;
    active_nxt = active_eff && !is_cr;
    count_nxt  = count_r;
    if (active_eff) begin
      if (!is_cr) begin
        if (count_r < CNT_W'(CMD_DEPTH)) begin
          res.wr    = 1'b1;
          res.index = srfe_pkg::IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end else begin
          res.ovf = 1'b1;
        end
      end else begin
        res.done   = 1'b1;
        res.length = srfe_pkg::LEN_W'(count_r);
        count_nxt  = '0;
      end
    end
  end

  // Capture state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/srfe_addr_capture.sv */
// ----------------------------------------------------------------------------
// Address capture
// A five-state matcher looks for the text "addr="; after it, bytes up to a
// space are stored as the address, the equals sign first.
// ----------------------------------------------------------------------------
module srfe_addr_capture #(
  parameter int unsigned IP_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output srfe_pkg::cap_res_t res
);

  localparam int unsigned CNT_W = $clog2(IP_DEPTH + 1);

  typedef enum logic [2:0] {
    M_A,
    M_D1,
    M_D2,
    M_R,
    M_EQ
  } match_t;

  match_t           stage_r;
  match_t           stage_nxt;
  logic             active_r;
  logic             active_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [7:0]       expect_ch;
  logic             hit;
  logic             active_eff;

  // Character the matcher waits for in each state.
  always_comb begin
    unique case (stage_r)
      M_A:     expect_ch = srfe_pkg::CH_A;
      M_D1:    expect_ch = srfe_pkg::CH_D;
      M_D2:    expect_ch = srfe_pkg::CH_D;
      M_R:     expect_ch = srfe_pkg::CH_R;
      M_EQ:    expect_ch = srfe_pkg::CH_EQ;
      default: expect_ch = srfe_pkg::CH_A;
    endcase
  end

  // Matcher step; a mismatch falls back without looking at the byte again.
  always_comb begin
    hit       = 1'b0;
    stage_nxt = M_A;
    if (rx_byte == expect_ch) begin
      unique case (stage_r)
        M_A:     stage_nxt = M_D1;
        M_D1:    stage_nxt = M_D2;
        M_D2:    stage_nxt = M_R;
        M_R:     stage_nxt = M_EQ;
        M_EQ:    hit       = 1'b1;
        default: stage_nxt = M_A;
      endcase
    end
  end

  assign active_eff = active_r || hit;

  // Capture result and next capture state.
  always_comb begin
    res        = '0;
    active_nxt = active_eff;
    count_nxt  = count_r;
    if (active_eff) begin
      if (rx_byte == srfe_pkg::CH_SPACE) begin
        res.done   = 1'b1;
        res.length = srfe_pkg::LEN_W'(count_r);
        count_nxt  = '0;
        active_nxt = 1'b0;
      end else if (count_r < CNT_W'(IP_DEPTH)) begin
        res.wr    = 1'b1;
        res.index = srfe_pkg::IDX_W'(count_r);
        count_nxt = count_r + CNT_W'(1);
      end else begin
        res.ovf = 1'b1;
      end
    end
  end

  // Matcher and capture state advance once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= M_A;
      active_r <= 1'b0;
      count_r  <= '0;
    end else if (step) begin
      stage_r  <= stage_nxt;
      active_r <= active_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/serial_reply_field_extractor_unit.sv */
// A byte transfer loads the input register; the result register loads its
// result once free. Throughput: one byte per cycle while out_ready holds,
// set by the single pass from the input register through the capture logic
// to the result register. Reset (rst_n low, synchronous) empties both
// registers, rewinds the ring position, stops both captures and returns
// the matcher to its start.
// ----------------------------------------------------------------------------
// Serial reply field extractor
// Echoes each received byte with its ring slot and extracts the command
// and the address fields from the byte stream.
// ----------------------------------------------------------------------------
module serial_reply_field_extractor_unit #(
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned CMD_DEPTH  = 32,
  parameter int unsigned IP_DEPTH   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic [3:0] out_ring_slot,
  output logic       out_cmd_start,
  output logic       out_cmd_write,
  output logic [4:0] out_cmd_index,
  output logic       out_cmd_done,
  output logic [5:0] out_cmd_length,
  output logic       out_ip_write,
  output logic [4:0] out_ip_index,
  output logic       out_ip_done,
  output logic [5:0] out_ip_length,
  output logic       out_overflow
);

  localparam int unsigned RING_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r;
  logic              out_free;
  logic              step;
  logic [RING_W-1:0] ring_pos_r;
  logic [RING_W-1:0] ring_pos_nxt;

  srfe_pkg::cap_res_t cmd_res;
  srfe_pkg::cap_res_t ip_res;

  // Handshake: the result register frees when empty or when taken.
  assign out_free  = !out_valid_r || out_ready;
  assign step      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Ring write position wraps at the ring depth.
  assign ring_pos_nxt = (ring_pos_r == RING_W'(RING_DEPTH - 1)) ? '0
                                                                 : ring_pos_r + RING_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r <= '0;
    end else if (step) begin
      ring_pos_r <= ring_pos_nxt;
    end
  end

  // Capture units.
  srfe_cmd_capture #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_cmd (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .res     (cmd_res)
  );

  srfe_addr_capture #(
    .IP_DEPTH (IP_DEPTH)
  ) u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .res     (ip_res)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (step) begin
      out_echo_byte  <= s1_byte_r;
      out_ring_slot  <= srfe_pkg::SLOT_W'(ring_pos_r);
      out_cmd_start  <= (s1_byte_r == srfe_pkg::CH_DOLLAR);
      out_cmd_write  <= cmd_res.wr;
      out_cmd_index  <= cmd_res.index;
      out_cmd_done   <= cmd_res.done;
      out_cmd_length <= cmd_res.length;
      out_ip_write   <= ip_res.wr;
      out_ip_index   <= ip_res.index;
      out_ip_done    <= ip_res.done;
      out_ip_length  <= ip_res.length;
      out_overflow   <= cmd_res.ovf || ip_res.ovf;
    end
  end

endmodule

/* rtl/srfe_checker.sv */
// ----------------------------------------------------------------------------
// Serial reply field extractor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module srfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_echo_byte,
  input logic       out_cmd_start,
  input logic       out_cmd_write,
  input logic       out_cmd_done,
  input logic       out_ip_done
);

  // A stalled result transfer holds its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_echo_byte))
    else $error("result changed while stalled");

  // A carriage return ends a command but is never stored in it.
  a_cmd_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_done |-> out_echo_byte == srfe_pkg::CH_CR && !out_cmd_write)
    else $error("command end without carriage return");

  // The dollar sign flag follows the byte and opens or extends a capture.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_start |->
      out_echo_byte == srfe_pkg::CH_DOLLAR && !out_cmd_done)
    else $error("start flag on wrong byte");

  // Only a space ends an address capture.
  a_ip_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_done |-> out_echo_byte == srfe_pkg::CH_SPACE)
    else $error("address end without space");

endmodule

bind serial_reply_field_extractor_unit srfe_checker u_srfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_echo_byte  (out_echo_byte),
  .out_cmd_start  (out_cmd_start),
  .out_cmd_write  (out_cmd_write),
  .out_cmd_done   (out_cmd_done),
  .out_ip_done    (out_ip_done)
);

/* sim/field_extract_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Field extraction checker
// Watches both channels of the serial reply field extractor, predicts the
// result of every accepted byte and compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module field_extract_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_echo_byte,
  input  logic [3:0] out_ring_slot,
  input  logic       out_cmd_start,
  input  logic       out_cmd_write,
  input  logic [4:0] out_cmd_index,
  input  logic       out_cmd_done,
  input  logic [5:0] out_cmd_length,
  input  logic       out_ip_write,
  input  logic [4:0] out_ip_index,
  input  logic       out_ip_done,
  input  logic [5:0] out_ip_length,
  input  logic       out_overflow,
  output int         mismatches,
  output int         pending,
  output int         checked,
  output int         cmds_closed,
  output int         addrs_closed,
  output int         drops
);

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned CMD_DEPTH  = 32;
  localparam int unsigned IP_DEPTH   = 32;

  // Everything one byte produces on the result channel.
  typedef struct packed {
    logic [7:0] echo;
    logic [3:0] slot;
    logic       start;
    logic       cmd_wr;
    logic [4:0] cmd_idx;
    logic       cmd_done;
    logic [5:0] cmd_len;
    logic       ip_wr;
    logic [4:0] ip_idx;
    logic       ip_done;
    logic [5:0] ip_len;
    logic       ovf;
  } rx_result_t;

  // Predicted extractor state.
  bit          cmd_active;
  int unsigned cmd_count;
  int unsigned match_stage;
  bit          ip_active;
  int unsigned ip_count;
  int unsigned ring_pos;

  rx_result_t  pending_replies[$];

  // Character that the address matcher waits for at each stage.
  function automatic logic [7:0] match_char(input int unsigned stage);
    case (stage)
      0:       return srfe_pkg::CH_A;
      1:       return srfe_pkg::CH_D;
      2:       return srfe_pkg::CH_D;
      3:       return srfe_pkg::CH_R;
      default: return srfe_pkg::CH_EQ;
    endcase
  endfunction

  // Advance the predicted state by one byte and return its result.
  function automatic rx_result_t extract_fields(input logic [7:0] rx);
    rx_result_t r;
    r = '0;
    r.echo = rx;
    r.slot = ring_pos[3:0];
    ring_pos = (ring_pos + 1) % RING_DEPTH;

    // Command capture runs from a dollar up to a carriage return.
    if (rx == srfe_pkg::CH_DOLLAR) begin
      cmd_active = 1'b1;
      r.start = 1'b1;
    end
    if (cmd_active) begin
      if (rx != srfe_pkg::CH_CR) begin
        if (cmd_count < CMD_DEPTH) begin
          r.cmd_wr  = 1'b1;
          r.cmd_idx = cmd_count[4:0];
          cmd_count++;
        end else begin
          r.ovf = 1'b1;
        end
      end else begin
        r.cmd_done = 1'b1;
        r.cmd_len  = cmd_count[5:0];
        cmd_count  = 0;
        cmd_active = 1'b0;
      end
    end

    // The matcher drops back to its start on a mismatch without a retry.
    if (match_stage > 4) match_stage = 0;
    if (rx == match_char(match_stage)) begin
      if (match_stage == 4) begin
        ip_active   = 1'b1;
        match_stage = 0;
      end else begin
        match_stage++;
      end
    end else begin
      match_stage = 0;
    end

    // Address capture starts with the equals sign and ends at a space.
    if (ip_active) begin
      if (rx == srfe_pkg::CH_SPACE) begin
        r.ip_done = 1'b1;
        r.ip_len  = ip_count[5:0];
        ip_count  = 0;
        ip_active = 1'b0;
      end else if (ip_count < IP_DEPTH) begin
        r.ip_wr  = 1'b1;
        r.ip_idx = ip_count[4:0];
        ip_count++;
      end else begin
        r.ovf = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are compared before the same edge's input is predicted; with the
  // input and result registers in between, no result belongs to a byte of that edge.
  always @(posedge clk) begin : monitor
    rx_result_t want;
    if (!rst_n) begin
      cmd_active   = 1'b0;
      cmd_count    = 0;
      match_stage  = 0;
      ip_active    = 1'b0;
      ip_count     = 0;
      ring_pos     = 0;
      mismatches   = 0;
      checked      = 0;
      cmds_closed  = 0;
      addrs_closed = 0;
      drops        = 0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("result transfer with nothing expected: echo_byte 0x%0h", out_echo_byte);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("echo_byte",  want.echo,     out_echo_byte);
          check_field("ring_slot",  want.slot,     out_ring_slot);
          check_field("cmd_start",  want.start,    out_cmd_start);
          check_field("cmd_write",  want.cmd_wr,   out_cmd_write);
          check_field("cmd_index",  want.cmd_idx,  out_cmd_index);
          check_field("cmd_done",   want.cmd_done, out_cmd_done);
          check_field("cmd_length", want.cmd_len,  out_cmd_length);
          check_field("ip_write",   want.ip_wr,    out_ip_write);
          check_field("ip_index",   want.ip_idx,   out_ip_index);
          check_field("ip_done",    want.ip_done,  out_ip_done);
          check_field("ip_length",  want.ip_len,   out_ip_length);
          check_field("overflow",   want.ovf,      out_overflow);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = extract_fields(in_rx_byte);
        if (want.cmd_done) cmds_closed++;
        if (want.ip_done) addrs_closed++;
        if (want.ovf) drops++;
        pending_replies.push_back(want);
      end
    end
    pending = pending_replies.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial reply field extractor testbench
// Feeds a short directed byte stream and then random command, address,
// nested, broken and noise sequences under random sender gaps and receiver
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CHUNK_BYTES = 600;
  localparam int unsigned CHUNKS      = 3;

  // Kinds of random byte sequences.
  typedef enum int {
    SEQ_CMD,
    SEQ_ADDR,
    SEQ_NESTED,
    SEQ_BROKEN,
    SEQ_NOISE
  } seq_kind_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_echo_byte;
  logic [3:0] out_ring_slot;
  logic       out_cmd_start;
  logic       out_cmd_write;
  logic [4:0] out_cmd_index;
  logic       out_cmd_done;
  logic [5:0] out_cmd_length;
  logic       out_ip_write;
  logic [4:0] out_ip_index;
  logic       out_ip_done;
  logic [5:0] out_ip_length;
  logic       out_overflow;

  int mismatches;
  int pending;
  int checked;
  int cmds_closed;
  int addrs_closed;
  int drops;
  int bytes_sent;

  logic [7:0] rx_stream[$];

  serial_reply_field_extractor_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_echo_byte  (out_echo_byte),
    .out_ring_slot  (out_ring_slot),
    .out_cmd_start  (out_cmd_start),
    .out_cmd_write  (out_cmd_write),
    .out_cmd_index  (out_cmd_index),
    .out_cmd_done   (out_cmd_done),
    .out_cmd_length (out_cmd_length),
    .out_ip_write   (out_ip_write),
    .out_ip_index   (out_ip_index),
    .out_ip_done    (out_ip_done),
    .out_ip_length  (out_ip_length),
    .out_overflow   (out_overflow)
  );

  field_extract_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_echo_byte  (out_echo_byte),
    .out_ring_slot  (out_ring_slot),
    .out_cmd_start  (out_cmd_start),
    .out_cmd_write  (out_cmd_write),
    .out_cmd_index  (out_cmd_index),
    .out_cmd_done   (out_cmd_done),
    .out_cmd_length (out_cmd_length),
    .out_ip_write   (out_ip_write),
    .out_ip_index   (out_ip_index),
    .out_ip_done    (out_ip_done),
    .out_ip_length  (out_ip_length),
    .out_overflow   (out_overflow),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked),
    .cmds_closed    (cmds_closed),
    .addrs_closed   (addrs_closed),
    .drops          (drops)
  );

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // The receiver stalls in modes that it picks anew after a random run:
  // always ready, random, mostly stalled and a fixed rhythm.
  initial begin : receiver
    int mode;
    int left;
    int phase;
    out_ready = 1'b0;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      phase++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (phase % 4 != 0);
      endcase
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
  endtask

  // Random capture content that avoids the given terminators; the marker
  // characters come up often so that nested starts and false matches occur.
  task automatic queue_body(input int n, input logic [7:0] stop_a,
                            input logic [7:0] stop_b);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do begin
        case ($urandom_range(0, 7))
          0:       c = srfe_pkg::CH_DOLLAR;
          1:       c = srfe_pkg::CH_A;
          2:       c = srfe_pkg::CH_D;
          default: c = 8'($urandom_range(0, 255));
        endcase
      end while (c == stop_a || c == stop_b);
      rx_stream.push_back(c);
    end
  endtask

  // Mostly short captures, now and then one long enough to fill the buffer.
  function automatic int body_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(28, 40);
    return $urandom_range(0, 8);
  endfunction

  task automatic queue_sequence();
    seq_kind_t kind;
    int pick;
    int k;
    string addr_text;
    addr_text = "addr=";
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = SEQ_CMD;
    else if (pick < 60) kind = SEQ_ADDR;
    else if (pick < 75) kind = SEQ_NESTED;
    else if (pick < 90) kind = SEQ_BROKEN;
    else                kind = SEQ_NOISE;
    case (kind)
      SEQ_CMD: begin
        rx_stream.push_back(srfe_pkg::CH_DOLLAR);
        queue_body(body_len(), srfe_pkg::CH_CR, srfe_pkg::CH_CR);
        rx_stream.push_back(srfe_pkg::CH_CR);
      end
      SEQ_ADDR: begin
        queue_text(addr_text);
        queue_body(body_len(), srfe_pkg::CH_SPACE, srfe_pkg::CH_SPACE);
        rx_stream.push_back(srfe_pkg::CH_SPACE);
      end
      SEQ_NESTED: begin
        rx_stream.push_back(srfe_pkg::CH_DOLLAR);
        queue_body($urandom_range(0, 4), srfe_pkg::CH_CR, srfe_pkg::CH_SPACE);
        queue_text(addr_text);
        queue_body(body_len(), srfe_pkg::CH_CR, srfe_pkg::CH_SPACE);
        rx_stream.push_back(srfe_pkg::CH_SPACE);
        queue_body($urandom_range(0, 4), srfe_pkg::CH_CR, srfe_pkg::CH_SPACE);
        rx_stream.push_back(srfe_pkg::CH_CR);
      end
      SEQ_BROKEN: begin
        case ($urandom_range(0, 2))
          0: begin
            k = $urandom_range(1, 4);
            queue_text(addr_text.substr(0, k - 1));
            rx_stream.push_back(8'($urandom_range(0, 255)));
          end
          1: queue_text("aaddr=");
          default: begin
            // A command start that is left open for a later sequence.
            rx_stream.push_back(srfe_pkg::CH_DOLLAR);
            queue_body($urandom_range(0, 6), srfe_pkg::CH_CR, srfe_pkg::CH_CR);
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Sends the queued bytes in bursts with random gaps; called at a falling
  // edge and returns at one.
  task automatic send_stream();
    int burst;
    int gap;
    burst = 0;
    while (rx_stream.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid   <= 1'b1;
      in_rx_byte <= rx_stream.pop_front();
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
      burst--;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    bytes_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, terminators with no capture open, a command
    // of one byte, a false match, a real match, a dollar inside an open
    // command and both terminators while the address capture runs.
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(srfe_pkg::CH_CR);
    rx_stream.push_back(srfe_pkg::CH_SPACE);
    rx_stream.push_back(srfe_pkg::CH_DOLLAR);
    rx_stream.push_back(srfe_pkg::CH_CR);
    queue_text("aaddr=");
    queue_text("addr=");
    rx_stream.push_back(srfe_pkg::CH_DOLLAR);
    rx_stream.push_back(srfe_pkg::CH_DOLLAR);
    rx_stream.push_back(srfe_pkg::CH_CR);
    rx_stream.push_back(srfe_pkg::CH_SPACE);
    send_stream();
    wait_drained();

    // Random chunks; the sender holds off between them until all is back.
    repeat (CHUNKS) begin
      while (rx_stream.size() < CHUNK_BYTES) queue_sequence();
      send_stream();
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d bytes, checked %0d results.", bytes_sent, checked);
    $display("Commands closed %0d, addresses closed %0d, dropped writes %0d.",
             cmds_closed, addrs_closed, drops);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* serial_reply_field_extractor_unit.f */
rtl/srfe_pkg.sv
rtl/srfe_cmd_capture.sv
rtl/srfe_addr_capture.sv
rtl/serial_reply_field_extractor_unit.sv
rtl/srfe_checker.sv
sim/field_extract_checker.sv
sim/tb_top.sv
